// ----- rtl/core/nrcc_pkg.sv -----
// Package: shared types, codes and constants of the nearest reference color classifier.
`timescale 1ns / 1ps

package nrcc_pkg;

  // Command codes of an input transfer
  typedef enum logic {
    CmdStore    = 1'b0,
    CmdClassify = 1'b1
  } cmd_e;

  // Color tags with a special role
  localparam logic [3:0] TagBlack = 4'd9;
  localparam logic [3:0] TagWhite = 4'd10;
  localparam logic [3:0] TagGray  = 4'd11;

  // Squared distance needs 34 bits (3 * 65535^2)
  localparam int unsigned DistW = 34;
  localparam logic [DistW-1:0] DistLimit = 34'd1000000000;

  // Brightness weights, sum scaled by 1024
  localparam logic [9:0] LumaCoefR = 10'd218;
  localparam logic [9:0] LumaCoefG = 10'd732;
  localparam logic [9:0] LumaCoefB = 10'd74;
  localparam int unsigned LumaW = 26;

  // Drive modes
  localparam logic [2:0] ModeNone     = 3'd0;
  localparam logic [2:0] ModeForward  = 3'd1;
  localparam logic [2:0] ModeBackward = 3'd2;
  localparam logic [2:0] ModeLeft     = 3'd3;
  localparam logic [2:0] ModeRight    = 3'd4;
  localparam logic [2:0] ModeOnce     = 3'd5;
  localparam logic [2:0] ModeTwice    = 3'd6;
  localparam logic [2:0] ModeThrice   = 3'd7;

  // Color tag to drive mode
  function automatic logic [2:0] mode_of_tag(input logic [3:0] tag);
    logic [2:0] mode;
    case (tag)
      4'd0:    mode = ModeBackward;  // red
      4'd2:    mode = ModeRight;     // yellow
      4'd3:    mode = ModeForward;   // green
      4'd4:    mode = ModeLeft;      // blue
      4'd5:    mode = ModeOnce;      // purple
      4'd7:    mode = ModeThrice;    // sky blue
      4'd8:    mode = ModeTwice;     // pink
      default: mode = ModeNone;
    endcase
    return mode;
  endfunction

  // Controller to datapath commands
  typedef struct packed {
    logic capture;      // latch the input transfer, reset the search
    logic write_entry;  // store the latched sample into its table
    logic issue;        // feed the entry at the scan index into the pipeline
    logic load_result;  // load the result registers
  } ctrl_cmd_t;

endpackage

// ----- rtl/core/nrcc_ctrl.sv -----
// Controller: sequences store and classify transfers and raises the result strobe.
`timescale 1ns / 1ps

module nrcc_ctrl
  import nrcc_pkg::*;
#(
  parameter int unsigned NUM_COLORS = 12,
  parameter int unsigned IdxW       = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            cmd_i,
  output logic            busy_o,
  output logic            done_o,
  output ctrl_cmd_t       ctrl_o,
  output logic [IdxW-1:0] scan_idx_o
);

  // Final drain count: the last issued entry then reaches the minimum stage
  localparam logic [1:0] DrainLast = 2'd2;
  localparam logic [IdxW-1:0] ScanLast = IdxW'(NUM_COLORS - 1);

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StStore  = 5'b00010,
    StScan   = 5'b00100,
    StDrain  = 5'b01000,
    StFinish = 5'b10000
  } state_e;

  state_e          state_q, state_d;
  logic [IdxW-1:0] scan_q, scan_d;
  logic [1:0]      drain_q, drain_d;
  logic            done_q;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    scan_d  = scan_q;
    drain_d = drain_q;
    ctrl_o  = '0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          ctrl_o.capture = 1'b1;
          scan_d  = '0;
          drain_d = '0;
          state_d = (cmd_i == CmdStore) ? StStore : StScan;
        end
      end
      StStore: begin
        ctrl_o.write_entry = 1'b1;
        state_d = StFinish;
      end
      StScan: begin
        ctrl_o.issue = 1'b1;
        if (scan_q == ScanLast) begin
          state_d = StDrain;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      StDrain: begin
        if (drain_q == DrainLast) begin
          state_d = StFinish;
        end else begin
          drain_d = drain_q + 1'b1;
        end
      end
      StFinish: begin
        ctrl_o.load_result = 1'b1;
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      scan_q  <= '0;
      drain_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
      drain_q <= drain_d;
      done_q  <= ctrl_o.load_result;
    end
  end

  assign busy_o     = (state_q != StIdle);
  assign done_o     = done_q;
  assign scan_idx_o = scan_q;

endmodule

// ----- rtl/core/nrcc_datapath.sv -----
// Datapath: reference tables, distance pipeline, minimum tracking and result registers.
`timescale 1ns / 1ps

module nrcc_datapath
  import nrcc_pkg::*;
#(
  parameter int unsigned NUM_COLORS = 12,
  parameter int unsigned IdxW       = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ctrl_cmd_t       ctrl_i,
  input  logic [IdxW-1:0] scan_idx_i,
  input  logic            cmd_i,
  input  logic            side_i,
  input  logic [3:0]      color_index_i,
  input  logic [15:0]     red_i,
  input  logic [15:0]     green_i,
  input  logic [15:0]     blue_i,
  output logic [3:0]      color_o,
  output logic [2:0]      drive_mode_o,
  output logic [15:0]     black_difference_o,
  output logic [15:0]     white_difference_o,
  output logic            brighter_side_o,
  output logic [15:0]     mean_difference_o
);

  localparam logic [4:0] NumColorsW = 5'(NUM_COLORS);

  function automatic logic [15:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Latched transfer
  logic        cmd_q, side_q;
  logic [3:0]  idx_q;
  logic [15:0] red_q, green_q, blue_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q   <= cmd_i;
      side_q  <= side_i;
      idx_q   <= color_index_i;
      red_q   <= red_i;
      green_q <= green_i;
      blue_q  <= blue_i;
    end
  end

  // Reference tables; an entry that is not valid reads as RGB 0, tag 0
  logic [15:0] tab_r_q [2][NUM_COLORS];
  logic [15:0] tab_g_q [2][NUM_COLORS];
  logic [15:0] tab_b_q [2][NUM_COLORS];
  logic [NUM_COLORS-1:0] valid_q [2];

  logic            idx_in_range;
  logic [IdxW-1:0] wr_idx;
  logic [LumaW-1:0] luma;

  assign idx_in_range = ({1'b0, idx_q} < NumColorsW);
  assign wr_idx       = idx_q[IdxW-1:0];
  assign luma = LumaW'(LumaCoefR) * LumaW'(red_q) + LumaW'(LumaCoefG) * LumaW'(green_q)
              + LumaW'(LumaCoefB) * LumaW'(blue_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.write_entry && idx_in_range) begin
      tab_r_q[side_q][wr_idx] <= red_q;
      tab_g_q[side_q][wr_idx] <= green_q;
      tab_b_q[side_q][wr_idx] <= blue_q;
    end
  end

  // Valid bits and black/white brightness per side
  logic [15:0] black_q [2];
  logic [15:0] white_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= '0;
      valid_q[1] <= '0;
      black_q[0] <= '0;
      black_q[1] <= '0;
      white_q[0] <= '0;
      white_q[1] <= '0;
    end else if (ctrl_i.write_entry && idx_in_range) begin
      valid_q[side_q][wr_idx] <= 1'b1;
      if (idx_q == TagBlack) begin
        black_q[side_q] <= luma[LumaW-1:10];
      end
      if (idx_q == TagWhite) begin
        white_q[side_q] <= luma[LumaW-1:10];
      end
    end
  end

  // Stage 1: read entry, channel differences
  logic        ent_valid;
  logic [15:0] ent_r, ent_g, ent_b;
  logic        v1_q, v2_q, v3_q;
  logic [15:0] dr_q, dg_q, db_q;
  logic [3:0]  tag1_q, tag2_q, tag3_q;

  assign ent_valid = valid_q[side_q][scan_idx_i];
  assign ent_r     = ent_valid ? tab_r_q[side_q][scan_idx_i] : '0;
  assign ent_g     = ent_valid ? tab_g_q[side_q][scan_idx_i] : '0;
  assign ent_b     = ent_valid ? tab_b_q[side_q][scan_idx_i] : '0;

  // Stage 2: squares; stage 3: sum
  logic [31:0]      sq_r_q, sq_g_q, sq_b_q;
  logic [DistW-1:0] dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= ctrl_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dr_q   <= abs_diff(red_q, ent_r);
    dg_q   <= abs_diff(green_q, ent_g);
    db_q   <= abs_diff(blue_q, ent_b);
    tag1_q <= ent_valid ? 4'(scan_idx_i) : 4'd0;
    sq_r_q <= 32'(dr_q) * 32'(dr_q);
    sq_g_q <= 32'(dg_q) * 32'(dg_q);
    sq_b_q <= 32'(db_q) * 32'(db_q);
    tag2_q <= tag1_q;
    dist_q <= DistW'(sq_r_q) + DistW'(sq_g_q) + DistW'(sq_b_q);
    tag3_q <= tag2_q;
  end

  // Stage 4: running minimum, first minimum kept
  logic [DistW-1:0] best_q;
  logic [3:0]       best_tag_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      best_q     <= DistLimit;
      best_tag_q <= TagGray;
    end else if (v3_q && (dist_q < best_q)) begin
      best_q     <= dist_q;
      best_tag_q <= tag3_q;
    end
  end

  // Result registers
  logic [15:0] dblack, dwhite;
  logic [16:0] dsum;

  assign dblack = abs_diff(black_q[0], black_q[1]);
  assign dwhite = abs_diff(white_q[0], white_q[1]);
  assign dsum   = {1'b0, dblack} + {1'b0, dwhite};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_result) begin
      color_o            <= (cmd_q == CmdClassify) ? best_tag_q : 4'd0;
      drive_mode_o       <= (cmd_q == CmdClassify) ? mode_of_tag(best_tag_q) : ModeNone;
      black_difference_o <= dblack;
      white_difference_o <= dwhite;
      brighter_side_o    <= (black_q[0] > black_q[1]) ? 1'b0 : 1'b1;
      mean_difference_o  <= dsum[16:1];
    end
  end

endmodule

// ----- rtl/core/nearest_reference_color_classifier_unit.sv -----
// Top level: nearest reference color classifier, controller plus datapath.
`timescale 1ns / 1ps

// A transfer is taken when start is high and busy is low. A store goes
// through the store and finish states; a classify goes through the scan,
// drain and finish states: the stored references of one side are walked one per
// cycle through a four-stage squared-distance pipeline. Each transfer gives
// exactly one result, shown for one cycle with done_o high; the receiver
// cannot stall it. busy falls in the cycle the result appears, so a new
// transfer may be taken while the result is on the ports.
module nearest_reference_color_classifier_unit
  import nrcc_pkg::*;
#(
  parameter int unsigned NUM_COLORS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cmd_i,
  input  logic        side_i,
  input  logic [3:0]  color_index_i,
  input  logic [15:0] red_i,
  input  logic [15:0] green_i,
  input  logic [15:0] blue_i,
  output logic        done_o,
  output logic [3:0]  color_o,
  output logic [2:0]  drive_mode_o,
  output logic [15:0] black_difference_o,
  output logic [15:0] white_difference_o,
  output logic        brighter_side_o,
  output logic [15:0] mean_difference_o
);

  localparam int unsigned IdxW = $clog2(NUM_COLORS);

  ctrl_cmd_t       ctrl;
  logic [IdxW-1:0] scan_idx;

  nrcc_ctrl #(
    .NUM_COLORS(NUM_COLORS),
    .IdxW      (IdxW)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .cmd_i     (cmd_i),
    .busy_o    (busy),
    .done_o    (done_o),
    .ctrl_o    (ctrl),
    .scan_idx_o(scan_idx)
  );

  nrcc_datapath #(
    .NUM_COLORS(NUM_COLORS),
    .IdxW      (IdxW)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctrl_i            (ctrl),
    .scan_idx_i        (scan_idx),
    .cmd_i             (cmd_i),
    .side_i            (side_i),
    .color_index_i     (color_index_i),
    .red_i             (red_i),
    .green_i           (green_i),
    .blue_i            (blue_i),
    .color_o           (color_o),
    .drive_mode_o      (drive_mode_o),
    .black_difference_o(black_difference_o),
    .white_difference_o(white_difference_o),
    .brighter_side_o   (brighter_side_o),
    .mean_difference_o (mean_difference_o)
  );

endmodule

// ----- sim/nrcc_result_checker.sv -----
// Result checker: predicts each transfer's result and compares it with what the block emits.
`timescale 1ns / 1ps

module nrcc_result_checker
  import nrcc_pkg::*;
#(
  parameter int unsigned NUM_COLORS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic        cmd_i,
  input  logic        side_i,
  input  logic [3:0]  color_index_i,
  input  logic [15:0] red_i,
  input  logic [15:0] green_i,
  input  logic [15:0] blue_i,
  input  logic        done_o,
  input  logic [3:0]  color_o,
  input  logic [2:0]  drive_mode_o,
  input  logic [15:0] black_difference_o,
  input  logic [15:0] white_difference_o,
  input  logic        brighter_side_o,
  input  logic [15:0] mean_difference_o,
  output int unsigned mismatch_count,
  output int unsigned pending_count
);

  // Color tags that map to a drive mode
  localparam logic [3:0] TagRed     = 4'd0;
  localparam logic [3:0] TagYellow  = 4'd2;
  localparam logic [3:0] TagGreen   = 4'd3;
  localparam logic [3:0] TagBlue    = 4'd4;
  localparam logic [3:0] TagPurple  = 4'd5;
  localparam logic [3:0] TagSkyBlue = 4'd7;
  localparam logic [3:0] TagPink    = 4'd8;

  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    logic [3:0]  color;
    logic [2:0]  drive_mode;
    logic [15:0] black_difference;
    logic [15:0] white_difference;
    logic        brighter_side;
    logic [15:0] mean_difference;
  } color_result_t;

  // Own copy of both reference tables
  logic [15:0] table_red   [2][NUM_COLORS];
  logic [15:0] table_green [2][NUM_COLORS];
  logic [15:0] table_blue  [2][NUM_COLORS];
  logic [3:0]  table_tag   [2][NUM_COLORS];
  logic [15:0] table_luma  [2][NUM_COLORS];

  color_result_t expected_q [$];

  function automatic logic [2:0] drive_mode_for(input logic [3:0] tag);
    logic [2:0] mode;
    case (tag)
      TagRed:     mode = ModeBackward;
      TagYellow:  mode = ModeRight;
      TagGreen:   mode = ModeForward;
      TagBlue:    mode = ModeLeft;
      TagPurple:  mode = ModeOnce;
      TagSkyBlue: mode = ModeThrice;
      TagPink:    mode = ModeTwice;
      default:    mode = ModeNone;
    endcase
    return mode;
  endfunction

  function automatic logic [15:0] luma_of(input logic [15:0] r, input logic [15:0] g,
                                          input logic [15:0] b);
    int unsigned sum;
    sum = LumaCoefR * int'(r) + LumaCoefG * int'(g) + LumaCoefB * int'(b);
    return sum[25:10];
  endfunction

  function automatic logic [15:0] abs_delta(input logic [15:0] a, input logic [15:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Brightness of a black or white reference; zero if the table is too short
  function automatic logic [15:0] reference_luma(input int unsigned s, input logic [3:0] idx);
    if (idx >= NUM_COLORS) return 16'd0;
    return table_luma[s][idx];
  endfunction

  // Applies one transfer to the tables and returns the result it causes
  function automatic color_result_t next_color_result(input logic cmd, input logic s,
                                                      input logic [3:0] idx,
                                                      input logic [15:0] r,
                                                      input logic [15:0] g,
                                                      input logic [15:0] b);
    color_result_t res;
    longint unsigned best, distance, dr, dg, db;
    logic [15:0] lb, rb, lw, rw;
    logic [16:0] sum;
    int unsigned i;
    res = '0;
    if (cmd == CmdStore) begin
      if (idx < NUM_COLORS) begin
        table_red[s][idx]   = r;
        table_green[s][idx] = g;
        table_blue[s][idx]  = b;
        table_tag[s][idx]   = idx;
        table_luma[s][idx]  = luma_of(r, g, b);
      end
    end else begin
      // nearest entry, strict compare keeps the first minimum
      best = 64'(DistLimit);
      res.color = TagGray;
      for (i = 0; i < NUM_COLORS; i++) begin
        dr = 64'(abs_delta(r, table_red[s][i]));
        dg = 64'(abs_delta(g, table_green[s][i]));
        db = 64'(abs_delta(b, table_blue[s][i]));
        distance = dr * dr + dg * dg + db * db;
        if (distance < best) begin
          best = distance;
          res.color = table_tag[s][i];
        end
      end
      res.drive_mode = drive_mode_for(res.color);
    end
    lb = reference_luma(0, TagBlack);
    rb = reference_luma(1, TagBlack);
    lw = reference_luma(0, TagWhite);
    rw = reference_luma(1, TagWhite);
    res.black_difference = abs_delta(lb, rb);
    res.white_difference = abs_delta(lw, rw);
    res.brighter_side = (lb > rb) ? 1'b0 : 1'b1;
    sum = {1'b0, res.black_difference} + {1'b0, res.white_difference};
    res.mean_difference = sum[16:1];
    return res;
  endfunction

  // Compare emitted results, then record the transfer taken at this edge
  always @(posedge clk_i or negedge rst_ni) begin
    color_result_t got, want;
    if (!rst_ni) begin
      for (int s = 0; s < 2; s++) begin
        for (int i = 0; i < NUM_COLORS; i++) begin
          table_red[s][i]   = '0;
          table_green[s][i] = '0;
          table_blue[s][i]  = '0;
          table_tag[s][i]   = '0;
          table_luma[s][i]  = '0;
        end
      end
      expected_q.delete();
      mismatch_count = 0;
      pending_count = 0;
    end else begin
      if (done_o) begin
        got = '{color_o, drive_mode_o, black_difference_o, white_difference_o,
                brighter_side_o, mean_difference_o};
        if (expected_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit)
            $display("%0t: result with no transfer outstanding: color %0d mode %0d",
                     $time, color_o, drive_mode_o);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= ReportLimit) begin
              $display("%0t: result mismatch", $time);
              $display("  expected color %0d mode %0d black %0d white %0d side %0d mean %0d",
                       want.color, want.drive_mode, want.black_difference,
                       want.white_difference, want.brighter_side, want.mean_difference);
              $display("  actual   color %0d mode %0d black %0d white %0d side %0d mean %0d",
                       got.color, got.drive_mode, got.black_difference,
                       got.white_difference, got.brighter_side, got.mean_difference);
            end
          end
        end
      end
      if (start && !busy)
        expected_q.push_back(next_color_result(cmd_i, side_i, color_index_i,
                                               red_i, green_i, blue_i));
      pending_count = expected_q.size();
    end
  end

endmodule

// ----- sim/nearest_reference_color_classifier_unit_tb.sv -----
// Testbench top: clock, reset, stimulus and verdict for the color classifier.
`timescale 1ns / 1ps

module nearest_reference_color_classifier_unit_tb;
  import nrcc_pkg::*;

  localparam int unsigned NUM_COLORS  = 12;
  localparam int unsigned RandomItems = 1350;
  localparam int unsigned PhaseLength = 150;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        start         = 1'b0;
  logic        busy;
  logic        cmd_i         = 1'b0;
  logic        side_i        = 1'b0;
  logic [3:0]  color_index_i = 4'd0;
  logic [15:0] red_i         = 16'd0;
  logic [15:0] green_i       = 16'd0;
  logic [15:0] blue_i        = 16'd0;
  logic        done_o;
  logic [3:0]  color_o;
  logic [2:0]  drive_mode_o;
  logic [15:0] black_difference_o;
  logic [15:0] white_difference_o;
  logic        brighter_side_o;
  logic [15:0] mean_difference_o;
  int unsigned mismatch_count;
  int unsigned pending_count;

  // Chance per cycle that the sender stays idle between transfers
  int unsigned sender_idle_pct = 0;

  // RGB last stored per entry, used to aim samples near references
  logic [15:0] stored_red   [2][NUM_COLORS];
  logic [15:0] stored_green [2][NUM_COLORS];
  logic [15:0] stored_blue  [2][NUM_COLORS];

  always #4 clk_i = ~clk_i;

  nearest_reference_color_classifier_unit #(
    .NUM_COLORS (NUM_COLORS)
  ) uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .cmd_i              (cmd_i),
    .side_i             (side_i),
    .color_index_i      (color_index_i),
    .red_i              (red_i),
    .green_i            (green_i),
    .blue_i             (blue_i),
    .done_o             (done_o),
    .color_o            (color_o),
    .drive_mode_o       (drive_mode_o),
    .black_difference_o (black_difference_o),
    .white_difference_o (white_difference_o),
    .brighter_side_o    (brighter_side_o),
    .mean_difference_o  (mean_difference_o)
  );

  nrcc_result_checker #(
    .NUM_COLORS (NUM_COLORS)
  ) result_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .cmd_i              (cmd_i),
    .side_i             (side_i),
    .color_index_i      (color_index_i),
    .red_i              (red_i),
    .green_i            (green_i),
    .blue_i             (blue_i),
    .done_o             (done_o),
    .color_o            (color_o),
    .drive_mode_o       (drive_mode_o),
    .black_difference_o (black_difference_o),
    .white_difference_o (white_difference_o),
    .brighter_side_o    (brighter_side_o),
    .mean_difference_o  (mean_difference_o),
    .mismatch_count     (mismatch_count),
    .pending_count      (pending_count)
  );

  // Drive one transfer and hold it until taken; then maybe idle a while
  task automatic send_item(input cmd_e cmd, input logic s, input logic [3:0] idx,
                           input logic [15:0] r, input logic [15:0] g, input logic [15:0] b);
    start         <= 1'b1;
    cmd_i         <= cmd;
    side_i        <= s;
    color_index_i <= idx;
    red_i         <= r;
    green_i       <= g;
    blue_i        <= b;
    do @(posedge clk_i); while (busy);
    if (cmd == CmdStore && idx < NUM_COLORS) begin
      stored_red[s][idx]   = r;
      stored_green[s][idx] = g;
      stored_blue[s][idx]  = b;
    end
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Hold off the sender until every outstanding result has come out
  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk_i); while (pending_count != 0);
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] near_value(input logic [15:0] base,
                                             input int unsigned spread);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * spread)) - int'(spread);
    if (v < 0) v = 0;
    else if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  function automatic logic [15:0] extreme_value();
    return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
  endfunction

  task automatic send_random_store();
    logic s;
    logic [3:0] idx;
    logic [15:0] r, g, b;
    int unsigned pick, src;
    s = 1'($urandom_range(0, 1));
    if (NUM_COLORS < 16 && $urandom_range(0, 99) < 8) idx = 4'($urandom_range(NUM_COLORS, 15));
    else idx = 4'($urandom_range(0, NUM_COLORS - 1));
    pick = $urandom_range(0, 99);
    src = $urandom_range(0, NUM_COLORS - 1);
    if (pick < 60) begin
      r = 16'($urandom_range(0, 65535));
      g = 16'($urandom_range(0, 65535));
      b = 16'($urandom_range(0, 65535));
    end else if (pick < 80) begin
      // duplicate of another entry: sets up ties
      r = stored_red[s][src];
      g = stored_green[s][src];
      b = stored_blue[s][src];
    end else begin
      r = extreme_value();
      g = extreme_value();
      b = extreme_value();
    end
    send_item(CmdStore, s, idx, r, g, b);
  endtask

  task automatic send_random_classify();
    logic s;
    logic [15:0] r, g, b;
    int unsigned pick, src;
    s = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    src = $urandom_range(0, NUM_COLORS - 1);
    if (pick < 45) begin
      r = near_value(stored_red[s][src], 3000);
      g = near_value(stored_green[s][src], 3000);
      b = near_value(stored_blue[s][src], 3000);
    end else if (pick < 55) begin
      r = stored_red[s][src];
      g = stored_green[s][src];
      b = stored_blue[s][src];
    end else if (pick < 80) begin
      r = 16'($urandom_range(0, 65535));
      g = 16'($urandom_range(0, 65535));
      b = 16'($urandom_range(0, 65535));
    end else if (pick < 90) begin
      // wide offsets land around the gray threshold
      r = near_value(stored_red[s][src], 20000);
      g = near_value(stored_green[s][src], 20000);
      b = near_value(stored_blue[s][src], 20000);
    end else begin
      r = extreme_value();
      g = extreme_value();
      b = extreme_value();
    end
    // color_index is ignored on classify; drive noise there
    send_item(CmdClassify, s, 4'($urandom_range(0, 15)), r, g, b);
  endtask

  // Stimulus and verdict
  initial begin
    int unsigned n, i;
    for (int s = 0; s < 2; s++) begin
      for (int k = 0; k < NUM_COLORS; k++) begin
        stored_red[s][k]   = '0;
        stored_green[s][k] = '0;
        stored_blue[s][k]  = '0;
      end
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset tables: all entries at RGB 0 with tag red
    send_item(CmdClassify, 1'b0, 4'd0, 16'd0, 16'd0, 16'd0);
    send_item(CmdClassify, 1'b1, 4'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // distance exactly at the limit is gray, a smaller distance is not
    send_item(CmdClassify, 1'b1, 4'd0, 16'd10000, 16'd30000, 16'd0);
    send_item(CmdClassify, 1'b1, 4'd0, 16'd10000, 16'd29999, 16'd0);

    // Store with index past the table writes nothing
    send_item(CmdStore, 1'b0, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF);

    // Fill the left table with distinct colors, black and white included
    for (i = 0; i < NUM_COLORS; i++)
      send_item(CmdStore, 1'b0, 4'(i), 16'(i * 5957), 16'(65535 - i * 5957),
                16'(i * i * 400));

    // Right black at full scale flips the brighter side flag
    send_item(CmdStore, 1'b1, TagBlack, 16'hFFFF, 16'hFFFF, 16'hFFFF);

    // Two right entries at the same RGB: the lower index wins
    send_item(CmdStore, 1'b1, 4'd3, 16'd20000, 16'd20000, 16'd20000);
    send_item(CmdStore, 1'b1, 4'd5, 16'd20000, 16'd20000, 16'd20000);
    send_item(CmdClassify, 1'b1, 4'd0, 16'd20001, 16'd20000, 16'd20000);

    // Exact hits on yellow through pink cover every remaining drive mode
    for (i = 2; i <= 8 && i < NUM_COLORS; i++)
      send_item(CmdClassify, 1'b0, 4'd0, stored_red[0][i], stored_green[0][i],
                stored_blue[0][i]);

    // Random part in phases of sender idling
    for (n = 0; n < RandomItems; n++) begin
      case ((n / PhaseLength) % 4)
        0:       sender_idle_pct = 0;
        1:       sender_idle_pct = 47;
        2:       sender_idle_pct = 0;
        default: sender_idle_pct = 19;
      endcase
      if (n == 400 || n == 900) wait_drained();
      if ($urandom_range(0, 99) < 30) send_random_store();
      else send_random_classify();
    end

    wait_drained();
    repeat (NUM_COLORS + 8) @(negedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("[nearest_reference_color_classifier_unit] OK");
    end else begin
      $display("[nearest_reference_color_classifier_unit] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("[nearest_reference_color_classifier_unit] ERROR");
    $finish;
  end

endmodule
